// ----- hw/rtl/ufr_pkg.sv -----
// shared types, constants and command/status structs for the union-find block
`default_nettype none
package ufr_pkg;

	// element index width and element count
	localparam int IDX_W        = 10;
	localparam int NUM_ELEMENTS = 1 << IDX_W;
	localparam int RANK_W       = 4;

	typedef logic [IDX_W-1:0]  node_t;
	typedef logic [RANK_W-1:0] rank_t;

	localparam rank_t RANK_MAX  = rank_t'(15);
	localparam rank_t RANK_INIT = rank_t'(1);

	// operation codes carried in kind
	localparam logic KIND_FIND  = 1'b0;
	localparam logic KIND_MERGE = 1'b1;

	// one memory word: rank and parent pointer of an element
	typedef struct packed {
		rank_t rank;
		node_t parent;
	} entry_t;

	// controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_B_RD,
		ST_B_CHK,
		ST_LINK_LO,
		ST_LINK_HI,
		ST_RESULT
	} state_t;

	// read address source
	typedef enum logic {
		RD_NODE,
		RD_PARENT
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    clr_write;
		logic    load_item;
		logic    step;
		logic    save_a;
		logic    start_b;
		logic    save_b;
		rd_sel_t rd_sel;
		logic    link_lo;
		logic    link_hi;
		logic    load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic is_root;
		logic is_merge;
		logic same_root;
		logic need_hi;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ufr_req_if.sv -----
// request channel: operation and element indices
`default_nettype none
interface ufr_req_if;
	logic                  valid;
	logic                  ready;
	logic                  kind;
	logic [ufr_pkg::IDX_W-1:0] elem_a;
	logic [ufr_pkg::IDX_W-1:0] elem_b;

	modport source (output valid, output kind, output elem_a, output elem_b, input ready);
	modport sink   (input valid, input kind, input elem_a, input elem_b, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ufr_rsp_if.sv -----
// response channel: leader and already-joined flag
`default_nettype none
interface ufr_rsp_if;
	logic                  valid;
	logic                  ready;
	logic [ufr_pkg::IDX_W-1:0] leader;
	logic                  already_joined;

	modport source (output valid, output leader, output already_joined, input ready);
	modport sink   (input valid, input leader, input already_joined, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ufr_ctrl.sv -----
// controller state machine for the union-find walks and link updates
`default_nettype none
module ufr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire ufr_pkg::status_t sts,
	output ufr_pkg::cmd_t         cmd
);
	import ufr_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_A_RD;
			end
			ST_A_RD: state_nxt = ST_A_CHK;
			ST_A_CHK: begin
				if (sts.is_root) state_nxt = sts.is_merge ? ST_B_RD : ST_RESULT;
			end
			ST_B_RD: state_nxt = ST_B_CHK;
			ST_B_CHK: begin
				if (sts.is_root) state_nxt = ST_LINK_LO;
			end
			ST_LINK_LO: begin
				if (sts.same_root || !sts.need_hi) state_nxt = ST_RESULT;
				else state_nxt = ST_LINK_HI;
			end
			ST_LINK_HI: state_nxt = ST_RESULT;
			ST_RESULT: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RD_NODE;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_write = 1'b1;
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			ST_A_CHK: begin
				if (sts.is_root) begin
					cmd.save_a  = 1'b1;
					cmd.start_b = sts.is_merge;
				end else begin
					cmd.step   = 1'b1;
					cmd.rd_sel = RD_PARENT;
				end
			end
			ST_B_CHK: begin
				if (sts.is_root) begin
					cmd.save_b = 1'b1;
				end else begin
					cmd.step   = 1'b1;
					cmd.rd_sel = RD_PARENT;
				end
			end
			ST_LINK_LO: cmd.link_lo = !sts.same_root;
			ST_LINK_HI: cmd.link_hi = 1'b1;
			ST_RESULT: cmd.load_out = sts.out_free;
			default: cmd.rd_sel = RD_NODE;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ufr_dp.sv -----
// datapath: link/rank memory, walk registers, root compare and result register
`default_nettype none
module ufr_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_kind,
	input  wire ufr_pkg::node_t    in_elem_a,
	input  wire ufr_pkg::node_t    in_elem_b,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ufr_pkg::node_t         out_leader,
	output logic                   out_already_joined,
	input  wire ufr_pkg::cmd_t     cmd,
	output ufr_pkg::status_t       sts
);
	import ufr_pkg::*;

	entry_t mem [NUM_ELEMENTS];
	entry_t rd_q;
	node_t  rd_addr;

	node_t  clr_q;
	logic   kind_q;
	node_t  elem_b_q;
	node_t  node_q;
	node_t  ra_q;
	node_t  rb_q;
	rank_t  rank_a_q;
	rank_t  rank_b_q;

	node_t  lo;
	node_t  hi;
	rank_t  rank_lo;
	rank_t  rank_hi;
	logic   same;

	logic   wr_en;
	node_t  wr_addr;
	entry_t wr_data;

	logic   out_valid_q;
	node_t  leader_q;
	logic   joined_q;

	// read address: current node, or the parent just read when stepping
	assign rd_addr = (cmd.rd_sel == RD_PARENT) ? rd_q.parent : node_q;

	// link/rank memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_q <= clr_q + node_t'(1);
		end
	end

	// walk and root registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q   <= in_kind;
			node_q   <= in_elem_a;
			elem_b_q <= in_elem_b;
		end else if (cmd.start_b) begin
			node_q <= elem_b_q;
		end else if (cmd.step) begin
			node_q <= rd_q.parent;
		end
		if (cmd.save_a) begin
			ra_q     <= node_q;
			rank_a_q <= rd_q.rank;
		end
		if (cmd.save_b) begin
			rb_q     <= node_q;
			rank_b_q <= rd_q.rank;
		end
	end

	// pick which root hangs under the other
	always_comb begin
		same = (ra_q == rb_q);
		if (rank_a_q > rank_b_q) begin
			lo      = rb_q;
			hi      = ra_q;
			rank_lo = rank_b_q;
			rank_hi = rank_a_q;
		end else begin
			lo      = ra_q;
			hi      = rb_q;
			rank_lo = rank_a_q;
			rank_hi = rank_b_q;
		end
	end

	// memory write port: sweep, hang the lower root, bump the upper rank
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '{rank: RANK_INIT, parent: clr_q};
		if (cmd.clr_write) begin
			wr_en = 1'b1;
		end else if (cmd.link_lo) begin
			wr_en   = 1'b1;
			wr_addr = lo;
			wr_data = '{rank: rank_lo, parent: hi};
		end else if (cmd.link_hi) begin
			wr_en   = 1'b1;
			wr_addr = hi;
			wr_data = '{rank: rank_hi + rank_t'(1), parent: hi};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (kind_q == KIND_MERGE) begin
				leader_q <= same ? ra_q : hi;
				joined_q <= same;
			end else begin
				leader_q <= ra_q;
				joined_q <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign out_leader         = leader_q;
	assign out_already_joined = joined_q;

	// status back to the controller
	always_comb begin
		sts.clr_last  = (clr_q == node_t'(NUM_ELEMENTS - 1));
		sts.is_root   = (rd_q.parent == node_q);
		sts.is_merge  = (kind_q == KIND_MERGE);
		sts.same_root = same;
		sts.need_hi   = (rank_a_q == rank_b_q) && (rank_hi < RANK_MAX);
		sts.out_free  = !out_valid_q || out_ready;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/union_find_by_rank.sv -----
// top level of the union-find-by-rank disjoint-set store
//
//   channel  dir  payload                      beat taken when
//   req      in   kind, elem_a, elem_b         req.valid && req.ready
//   rsp      out  leader, already_joined       rsp.valid && rsp.ready
//
// after reset a clearing sweep writes all 1024 entries, one per cycle; no req beat
// is taken during the sweep.
// one item at a time: each parent-chain step is one read of the single memory read port,
// so a find walks one parent chain and a merge walks two, with one more write when a
// root gains rank.
// the result register frees the walk: a new req beat is taken while rsp still stalls.
`default_nettype none
module union_find_by_rank (
	input  wire logic clk,
	input  wire logic arst_n,
	ufr_req_if.sink   req,
	ufr_rsp_if.source rsp
);
	import ufr_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// sequencer
	ufr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// memory and walk datapath
	ufr_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_kind            (req.kind),
		.in_elem_a          (req.elem_a),
		.in_elem_b          (req.elem_b),
		.out_valid          (rsp.valid),
		.out_ready          (rsp.ready),
		.out_leader         (rsp.leader),
		.out_already_joined (rsp.already_joined),
		.cmd                (cmd),
		.sts                (sts)
	);

endmodule
`default_nettype wire
